// ===== src/doc_pkg.sv =====
// Shared constants for the dust occupancy concentration core.
// Register indexes, field widths, reset values and curve constants.
// No dependencies.
package doc_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 26;
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_TICKS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MASS_FACTOR  = 2'd1;

   // field widths
   localparam int WINDOW_W  = 26;
   localparam int FACTOR_W  = 24;
   localparam int LOW_OUT_W = 26;
   localparam int RATIO_W   = 23;
   localparam int CONC_W    = 29;
   localparam int MASS_W    = 20;

   // register reset values
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 26'd30000000;
   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 24'd34883;

   // cubic curve 1.1 r^3 - 3.8 r^2 + 520 r + 0.62, r in Q.16
   localparam int CURVE_FRAC = 16;
   localparam int R16_W      = 23;
   localparam logic [R16_W-1:0] R16_TOP      = 23'd6553600;
   localparam logic [31:0]      CURVE_C380   = 32'd24903680;
   localparam logic [47:0]      CURVE_C52000 = 48'd223338299392000;
   localparam logic [35:0]      CONC_BIAS    = 36'd15922;
   localparam logic [MASS_W-1:0] MASS_MAX    = 20'd600000;

   // divide by 100 as two reciprocal steps over an 18-bit split
   localparam logic [18:0]      DIV100_HI_M  = 19'd335545;    // ceil(2^25 / 100)
   localparam logic [25:0]      DIV100_LO_M  = 26'd42949673;  // ceil(2^32 / 100)

   // window record queue between counter and arithmetic
   localparam int QUEUE_DEPTH = 2;

endpackage

// ===== src/doc_front.sv =====
// Front end: counts ticks and low samples, detects the end of a window.
// Uses doc_pkg for the window register width.
module doc_front import doc_pkg::*; #(
   parameter int COUNT_WIDTH = 26
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_pin_level,
   output logic                   req_stall,
   input  logic [WINDOW_W-1:0]    window_ticks,
   input  logic                   q_full,
   output logic                   push,
   output logic [COUNT_WIDTH-1:0] push_low,
   output logic [COUNT_WIDTH-1:0] push_ticks
);

   localparam int CMP_W = (COUNT_WIDTH > WINDOW_W) ? COUNT_WIDTH : WINDOW_W;

   logic [COUNT_WIDTH-1:0] tick_ff, tick_in;
   logic [COUNT_WIDTH-1:0] low_ff, low_in;
   logic [COUNT_WIDTH-1:0] ticks_next, low_next;
   logic [WINDOW_W-1:0]    win_eff;
   logic                   accept, window_end;

   // hold requests off only while the queue has no room
   assign req_stall = q_full;
   assign accept    = req_valid & ~q_full;

   // counts including the current sample; zero window acts as one
   always_comb begin
      win_eff    = (window_ticks == '0) ? WINDOW_W'(1) : window_ticks;
      ticks_next = tick_ff + COUNT_WIDTH'(1);
      low_next   = low_ff + {{(COUNT_WIDTH-1){1'b0}}, ~req_pin_level};
      window_end = (CMP_W'(ticks_next) >= CMP_W'(win_eff)) || (ticks_next == '1);
   end

   assign push       = accept & window_end;
   assign push_low   = low_next;
   assign push_ticks = ticks_next;

   always_comb begin
      tick_in = tick_ff;
      low_in  = low_ff;
      if (accept) begin
         if (window_end) begin
            tick_in = '0;
            low_in  = '0;
         end else begin
            tick_in = ticks_next;
            low_in  = low_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
         low_ff  <= '0;
      end else begin
         tick_ff <= tick_in;
         low_ff  <= low_in;
      end
   end

endmodule

// ===== src/doc_queue.sv =====
// Short queue of finished window records between front and back ends.
// Uses doc_pkg for the queue depth.
module doc_queue import doc_pkg::*; #(
   parameter int DATA_W = 52
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   output logic              valid,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = entry_ff[rd_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & valid;

   // pointer wrap and fill count
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== src/doc_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Used by doc_back for the occupancy ratio; no package dependency.
module doc_divider #(
   parameter int NUM_W = 49,
   parameter int DEN_W = 26
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   shifted, diff;
   logic             qbit;

   // shift in the next dividend bit, subtract where it fits
   always_comb begin
      shifted  = {rem_ff, num_ff[NUM_W-1]};
      diff     = shifted - {1'b0, den_ff};
      qbit     = (shifted >= {1'b0, den_ff});
      num_in   = num_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      if (start) begin
         num_in = dividend;
         rem_in = '0;
         den_in = divisor;
         cnt_in = CNT_W'(NUM_W);
      end else if (cnt_ff != '0) begin
         rem_in  = qbit ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         num_in  = {num_ff[NUM_W-2:0], qbit};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   assign done     = done_ff;
   assign quotient = num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

endmodule

// ===== src/doc_back.sv =====
// Back end: ratio, cubic curve and mass arithmetic on one window record,
// with the result register. Uses doc_pkg and doc_divider.
module doc_back import doc_pkg::*; #(
   parameter int COUNT_WIDTH = 26,
   parameter int FRAC_BITS   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  logic [COUNT_WIDTH-1:0] q_low,
   input  logic [COUNT_WIDTH-1:0] q_ticks,
   output logic                   q_pop,
   input  logic [FACTOR_W-1:0]    mass_factor,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [LOW_OUT_W-1:0]   rsp_low_time_us,
   output logic [RATIO_W-1:0]     rsp_ratio_q16,
   output logic [CONC_W-1:0]      rsp_concentration_q8,
   output logic [MASS_W-1:0]      rsp_mass_ugm3_q8
);

   // the ratio is divided once at the finer of the two fractions
   localparam int M      = (FRAC_BITS > CURVE_FRAC) ? FRAC_BITS : CURVE_FRAC;
   localparam int L100_W = COUNT_WIDTH + 7;
   localparam int NUM_W  = L100_W + M;
   localparam int D_W    = M + 7;
   localparam int RF_W   = FRAC_BITS + 7;
   localparam logic [RF_W-1:0] RATIO_TOP = RF_W'(100) << FRAC_BITS;
   localparam int V_W    = 36;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_DIV, ST_T1, ST_MUL1, ST_T2, ST_MUL_LO, ST_MUL_HI,
      ST_SUM, ST_BIAS, ST_DQH, ST_DRH, ST_DQL, ST_MMUL, ST_MFIN, ST_HOLD
   } state_type;

   state_type               state_ff;
   logic [COUNT_WIDTH-1:0]  low_ff, ticks_ff;
   logic [RF_W-1:0]         ratio_ff;
   logic [R16_W-1:0]        r16_ff;
   logic signed [31:0]      t1_ff;
   logic [52:0]             t2_ff;
   logic signed [57:0]      prod_ff, prod_in;
   logic [49:0]             lo_ff;
   logic [48:0]             hi_ff;
   logic [49:0]             sum_ff;
   logic [V_W-1:0]          q100_ff;
   logic [11:0]             qh_ff;
   logic [6:0]              rh_ff;
   logic [CONC_W-1:0]       conc_ff;
   logic [MASS_W-1:0]       mass_ff;
   logic                    rsp_valid_ff;
   logic [LOW_OUT_W-1:0]    rsp_low_ff;
   logic [RATIO_W-1:0]      rsp_ratio_ff;
   logic [CONC_W-1:0]       rsp_conc_ff;
   logic [MASS_W-1:0]       rsp_mass_ff;

   logic [L100_W-1:0]       low100;
   logic [NUM_W-1:0]        dividend, quotient;
   logic                    div_start, div_done;
   logic [D_W-1:0]          dq;
   logic [RF_W-1:0]         ratio_raw;
   logic [R16_W-1:0]        r16_raw;
   logic [29:0]             r110;
   logic signed [32:0]      mul_a;
   logic [23:0]             mul_b;
   logic signed [24:0]      mul_b_s;
   logic signed [57:0]      t2_sum;
   logic [17:0]             xh;
   logic [36:0]             dh_prod;
   logic [17:0]             rh_full;
   logic [24:0]             xl_join;
   logic [50:0]             dl_prod;
   logic [53:0]             mass_sum;
   logic [29:0]             mass_full;
   logic                    rsp_load;

   // ratio divider: (low * 100) << M over the ticks counted
   assign low100    = L100_W'(low_ff) * L100_W'(100);
   assign dividend  = {low100, {M{1'b0}}};
   assign div_start = (state_ff == ST_LOAD);

   doc_divider #(
      .NUM_W (NUM_W),
      .DEN_W (COUNT_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (ticks_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // both fractions come from the one quotient by truncation
   always_comb begin
      dq        = quotient[D_W-1:0];
      ratio_raw = dq[D_W-1 -: RF_W];
      r16_raw   = dq[D_W-1 -: R16_W];
   end

   // shared multiplier, signed 33 x unsigned 24
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MUL1: begin
            mul_a = {t1_ff[31], t1_ff};
            mul_b = {1'b0, r16_ff};
         end
         ST_MUL_LO: begin
            mul_a = {6'b0, t2_ff[26:0]};
            mul_b = {1'b0, r16_ff};
         end
         ST_MUL_HI: begin
            mul_a = {7'b0, t2_ff[52:27]};
            mul_b = {1'b0, r16_ff};
         end
         ST_MMUL: begin
            mul_a = {4'b0, conc_ff};
            mul_b = mass_factor;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_b_s = {1'b0, mul_b};
      prod_in = mul_a * mul_b_s;
   end

   // remaining datapath pieces
   always_comb begin
      r110      = 30'(r16_ff) * 30'(110);
      t2_sum    = prod_ff + $signed({10'b0, CURVE_C52000});
      // divide by 100: upper 18 bits first, then remainder joined to the lower 18
      xh        = q100_ff[V_W-1 -: 18];
      dh_prod   = 37'(xh) * 37'(DIV100_HI_M);
      rh_full   = xh - 18'(qh_ff) * 18'(100);
      xl_join   = {rh_ff, q100_ff[17:0]};
      dl_prod   = 51'(xl_join) * 51'(DIV100_LO_M);
      mass_sum  = prod_ff[53:0] + 54'(1 << 23);
      mass_full = mass_sum[53:24];
   end

   assign q_pop    = (state_ff == ST_IDLE) && q_valid;
   assign rsp_load = (state_ff == ST_HOLD) && (!rsp_valid_ff || !rsp_stall);

   // sequencer with result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  low_ff   <= q_low;
                  ticks_ff <= q_ticks;
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (div_done) begin
                  ratio_ff <= (ratio_raw > RATIO_TOP) ? RATIO_TOP : ratio_raw;
                  r16_ff   <= (r16_raw > R16_TOP) ? R16_TOP : r16_raw;
                  state_ff <= ST_T1;
               end
            end
            ST_T1: begin
               t1_ff    <= $signed({2'b00, r110}) - $signed(CURVE_C380);
               state_ff <= ST_MUL1;
            end
            ST_MUL1: begin
               prod_ff  <= prod_in;
               state_ff <= ST_T2;
            end
            ST_T2: begin
               t2_ff    <= t2_sum[52:0];
               state_ff <= ST_MUL_LO;
            end
            ST_MUL_LO: begin
               lo_ff    <= prod_in[49:0];
               state_ff <= ST_MUL_HI;
            end
            ST_MUL_HI: begin
               hi_ff    <= prod_in[48:0];
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               sum_ff   <= {1'b0, hi_ff} + 50'(lo_ff[49:27]);
               state_ff <= ST_BIAS;
            end
            ST_BIAS: begin
               q100_ff  <= V_W'(sum_ff[49:13]) + CONC_BIAS;
               state_ff <= ST_DQH;
            end
            ST_DQH: begin
               qh_ff    <= dh_prod[36:25];
               state_ff <= ST_DRH;
            end
            ST_DRH: begin
               rh_ff    <= rh_full[6:0];
               state_ff <= ST_DQL;
            end
            ST_DQL: begin
               conc_ff  <= CONC_W'({qh_ff, dl_prod[49:32]});
               state_ff <= ST_MMUL;
            end
            ST_MMUL: begin
               prod_ff  <= prod_in;
               state_ff <= ST_MFIN;
            end
            ST_MFIN: begin
               mass_ff  <= (mass_full > 30'(MASS_MAX)) ? MASS_MAX : mass_full[MASS_W-1:0];
               state_ff <= ST_HOLD;
            end
            ST_HOLD: begin
               if (rsp_load) begin
                  rsp_low_ff   <= LOW_OUT_W'(low_ff);
                  rsp_ratio_ff <= RATIO_W'(ratio_ff);
                  rsp_conc_ff  <= conc_ff;
                  rsp_mass_ff  <= mass_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_low_time_us      = rsp_low_ff;
   assign rsp_ratio_q16        = rsp_ratio_ff;
   assign rsp_concentration_q8 = rsp_conc_ff;
   assign rsp_mass_ugm3_q8     = rsp_mass_ff;

endmodule

// ===== src/dust_occupancy_concentration_core.sv =====
// Dust sensor low-pulse occupancy meter: configuration registers and top.
// Uses doc_pkg, doc_front, doc_queue and doc_back.
//
// Usage: one request per microsecond tick on req_, carrying the sampled
// sensor pin level. The block counts ticks and low samples; when the count
// reaches window_ticks (or the counter limit) it sends one response on rsp_
// with the low time, occupancy ratio, particle and mass concentration, and
// restarts the count. Ticks that do not end a window give no response.
// Throughput: one request per cycle while req_stall is low. A finished
// window is placed in a two-entry queue; the back end turns it into a
// response in a time set mostly by the bit-serial ratio divider.
// req_stall rises only when both queue entries hold windows not yet
// worked on, i.e. when windows end faster than the back end turns
// them into responses.
// A stalled response holds its payload; the next window waits in the back
// end and in the queue meanwhile.
// Reset: counters clear, queue empties, window_ticks returns to 30000000
// and mass_factor_q24 to 34883. Registers are to be written on csr_ only
// while idle; the block itself does not enforce it. csr_ready is always high.
module dust_occupancy_concentration_core import doc_pkg::*; #(
   parameter int COUNT_WIDTH = 26,
   parameter int FRAC_BITS   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_pin_level,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [LOW_OUT_W-1:0]   rsp_low_time_us,
   output logic [RATIO_W-1:0]     rsp_ratio_q16,
   output logic [CONC_W-1:0]      rsp_concentration_q8,
   output logic [MASS_W-1:0]      rsp_mass_ugm3_q8,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int REC_W = 2 * COUNT_WIDTH;

   logic [WINDOW_W-1:0]    window_ff;
   logic [FACTOR_W-1:0]    factor_ff;
   logic                   q_full, q_valid, q_pop, push;
   logic [COUNT_WIDTH-1:0] push_low, push_ticks;
   logic [REC_W-1:0]       q_data;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         factor_ff <= FACTOR_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_WINDOW_TICKS: window_ff <= csr_data[WINDOW_W-1:0];
            REG_MASS_FACTOR:  factor_ff <= csr_data[FACTOR_W-1:0];
            default: ;
         endcase
      end
   end

   doc_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_pin_level (req_pin_level),
      .req_stall     (req_stall),
      .window_ticks  (window_ff),
      .q_full        (q_full),
      .push          (push),
      .push_low      (push_low),
      .push_ticks    (push_ticks)
   );

   doc_queue #(
      .DATA_W (REC_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_low, push_ticks}),
      .full      (q_full),
      .valid     (q_valid),
      .pop       (q_pop),
      .pop_data  (q_data)
   );

   doc_back #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .q_valid              (q_valid),
      .q_low                (q_data[REC_W-1:COUNT_WIDTH]),
      .q_ticks              (q_data[COUNT_WIDTH-1:0]),
      .q_pop                (q_pop),
      .mass_factor          (factor_ff),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_low_time_us      (rsp_low_time_us),
      .rsp_ratio_q16        (rsp_ratio_q16),
      .rsp_concentration_q8 (rsp_concentration_q8),
      .rsp_mass_ugm3_q8     (rsp_mass_ugm3_q8)
   );

endmodule

// ===== test/dust_occupancy_concentration_core_test.sv =====
// Self-checking testbench for dust_occupancy_concentration_core: occupancy windows,
// ratio, cubic particle curve and mass scaling predicted per request and compared.
// Depends on doc_pkg and the core RTL only.
module dust_occupancy_concentration_core_test;
   import doc_pkg::*;

   localparam int COUNT_WIDTH   = 26;
   localparam int FRAC_BITS     = 16;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int SETTLE_CYCLES = 200;
   localparam int HOLD_CYCLES   = 800;
   localparam int RANDOM_ITEMS  = 1250;
   localparam longint unsigned COUNT_TOP = (64'd1 << COUNT_WIDTH) - 1;
   localparam logic [WINDOW_W-1:0] WINDOW_MAX = '1;
   localparam logic [FACTOR_W-1:0] FACTOR_MAX = '1;

   typedef struct packed {
      logic [LOW_OUT_W-1:0] low;
      logic [RATIO_W-1:0]   ratio;
      logic [CONC_W-1:0]    conc;
      logic [MASS_W-1:0]    mass;
   } window_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_pin_level = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [LOW_OUT_W-1:0]   rsp_low_time_us;
   logic [RATIO_W-1:0]     rsp_ratio_q16;
   logic [CONC_W-1:0]      rsp_concentration_q8;
   logic [MASS_W-1:0]      rsp_mass_ugm3_q8;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // pending pin samples and expected window results
   logic              pin_samples_q[$];
   window_result_type window_results_q[$];

   // predictor copy of registers and counters
   logic [WINDOW_W-1:0] window_setting;
   logic [FACTOR_W-1:0] factor_setting;
   longint unsigned     ticks_seen;
   longint unsigned     lows_seen;

   int  errors = 0;
   int  cycle_count = 0;
   int  sender_idle_pct = 17;
   int  receiver_idle_pct = 17;
   int  hold_requests = 0;
   int  hold_served = 0;
   int  hold_left = 0;
   bit  req_taken = 1'b0;

   dust_occupancy_concentration_core #(
      .COUNT_WIDTH(COUNT_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_pin_level       (req_pin_level),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_low_time_us     (rsp_low_time_us),
      .rsp_ratio_q16       (rsp_ratio_q16),
      .rsp_concentration_q8(rsp_concentration_q8),
      .rsp_mass_ugm3_q8    (rsp_mass_ugm3_q8),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #5 clock = ~clock;

   // percent occupancy, fixed point with frac fraction bits, clamped to 100
   function automatic longint unsigned occupancy_ratio(longint unsigned lows,
                                                       longint unsigned ticks, int frac);
      longint unsigned top, r;
      top = 64'd100 << frac;
      r   = ((lows * 64'd100) << frac) / ticks;
      return (r > top) ? top : r;
   endfunction

   // 1.1 r^3 - 3.8 r^2 + 520 r + 0.62 in Q.8, r in Q.16
   function automatic longint unsigned curve_concentration(longint unsigned r16);
      longint      rs, lin, cubic;
      logic [127:0] a, b, prod;
      rs    = r16;
      lin   = 110 * rs - 380 * (64'sd1 <<< CURVE_FRAC);
      cubic = lin * rs + 64'sd52000 * (64'sd1 <<< (2 * CURVE_FRAC));
      a     = cubic;
      b     = r16;
      prod  = a * b;
      // 0.62 in the same scale is 15872, plus 50 to round the divide by 100
      return (prod[103:40] + 64'd15872 + 64'd50) / 64'd100;
   endfunction

   // count one pin sample; at window end queue the expected result
   task automatic count_pin_sample(logic pin);
      longint unsigned   span, ticks, lows, ratio, r16, conc, mass;
      window_result_type res;
      span  = (window_setting == 0) ? 64'd1 : window_setting;
      ticks = ticks_seen + 1;
      lows  = lows_seen + (pin ? 0 : 1);
      if (ticks < span && ticks < COUNT_TOP) begin
         ticks_seen = ticks;
         lows_seen  = lows;
      end else begin
         ratio = occupancy_ratio(lows, ticks, FRAC_BITS);
         r16   = occupancy_ratio(lows, ticks, CURVE_FRAC);
         conc  = curve_concentration(r16);
         mass  = (conc * factor_setting + (64'd1 << 23)) >> 24;
         if (mass > MASS_MAX)
            mass = 64'(MASS_MAX);
         res.low   = lows[LOW_OUT_W-1:0];
         res.ratio = ratio[RATIO_W-1:0];
         res.conc  = conc[CONC_W-1:0];
         res.mass  = mass[MASS_W-1:0];
         window_results_q.push_back(res);
         ticks_seen = 0;
         lows_seen  = 0;
      end
   endtask

   task automatic check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // request driver: a new sample only once the previous one is taken
   always @(negedge clock) begin
      if (req_taken || !req_valid) begin
         req_taken = 1'b0;
         if (!reset && pin_samples_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_valid     <= 1'b1;
            req_pin_level <= pin_samples_q.pop_front();
         end else begin
            req_valid     <= 1'b0;
            req_pin_level <= 1'($urandom_range(1));
         end
      end
   end

   // response stall: random, or a long hold-off when one is requested
   always @(negedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   // monitor: register writes, accepted requests, accepted responses
   always @(posedge clock) begin : monitor
      window_result_type want;
      if (reset) begin
         window_setting = WINDOW_RESET;
         factor_setting = FACTOR_RESET;
         ticks_seen     = 0;
         lows_seen      = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_WINDOW_TICKS: window_setting = csr_data[WINDOW_W-1:0];
               REG_MASS_FACTOR:  factor_setting = csr_data[FACTOR_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (window_results_q.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual low %0d ratio %0d",
                        $time, rsp_low_time_us, rsp_ratio_q16);
               errors++;
            end else begin
               want = window_results_q.pop_front();
               check_field("low_time_us", want.low, rsp_low_time_us);
               check_field("ratio_q16", want.ratio, rsp_ratio_q16);
               check_field("concentration_q8", want.conc, rsp_concentration_q8);
               check_field("mass_ugm3_q8", want.mass, rsp_mass_ugm3_q8);
            end
         end
         if (req_valid && !req_stall) begin
            count_pin_sample(req_pin_level);
            req_taken = 1'b1;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // wait until every request is taken and every result seen, then let the
   // arithmetic run out
   task automatic settle();
      while (pin_samples_q.size() != 0 || req_valid || window_results_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_regs(logic [WINDOW_W-1:0] win, logic [FACTOR_W-1:0] fac);
      write_reg(REG_WINDOW_TICKS, win);
      write_reg(REG_MASS_FACTOR, CSR_DATA_W'(fac));
   endtask

   // knobs change just after a rising edge, clear of the driving processes
   task automatic start_stream(int snd_pct, int rcv_pct, bit hold);
      @(posedge clock);
      sender_idle_pct   = snd_pct;
      receiver_idle_pct = rcv_pct;
      if (hold)
         hold_requests++;
   endtask

   task automatic queue_random(int count, int low_pct);
      for (int k = 0; k < count; k++)
         pin_samples_q.push_back($urandom_range(99) >= low_pct);
   endtask

   initial begin : stimulus
      int                  random_items;
      int                  count;
      int                  low_pct;
      logic [WINDOW_W-1:0] win;
      logic [FACTOR_W-1:0] fac;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // one-tick windows: full and empty occupancy, mass saturation
      set_regs(1, FACTOR_MAX);
      start_stream(17, 17, 0);
      pin_samples_q.push_back(1'b0);
      pin_samples_q.push_back(1'b1);
      settle();

      // zero window behaves as one tick
      set_regs(0, FACTOR_RESET);
      start_stream(17, 17, 0);
      pin_samples_q.push_back(1'b0);
      pin_samples_q.push_back(1'b1);
      pin_samples_q.push_back(1'b0);
      settle();

      // three-tick windows, zero factor
      set_regs(3, 0);
      start_stream(17, 17, 0);
      pin_samples_q.push_back(1'b0);
      pin_samples_q.push_back(1'b1);
      pin_samples_q.push_back(1'b1);
      repeat (3) pin_samples_q.push_back(1'b1);
      repeat (3) pin_samples_q.push_back(1'b0);
      settle();

      // longest window, left part way through
      set_regs(WINDOW_MAX, FACTOR_RESET);
      start_stream(17, 17, 0);
      pin_samples_q.push_back(1'b1);
      pin_samples_q.push_back(1'b0);
      pin_samples_q.push_back(1'b1);
      pin_samples_q.push_back(1'b0);
      pin_samples_q.push_back(1'b0);
      settle();

      // window shortened below the count: ends on the next tick
      set_regs(4, FACTOR_MAX);
      start_stream(17, 17, 0);
      pin_samples_q.push_back(1'b1);
      pin_samples_q.push_back(1'b0);
      pin_samples_q.push_back(1'b1);
      pin_samples_q.push_back(1'b0);
      pin_samples_q.push_back(1'b1);
      settle();

      // receiver holds off while one-tick windows keep coming: input stalls
      set_regs(1, FACTOR_W'($urandom_range(FACTOR_MAX)));
      start_stream(0, 0, 1);
      queue_random(40, 50);
      settle();
      random_items = 40;

      // stretch with no idling on either side
      set_regs(WINDOW_W'($urandom_range(1, 8)), FACTOR_W'($urandom_range(FACTOR_MAX)));
      start_stream(0, 0, 0);
      queue_random(300, 50);
      settle();
      random_items += 300;

      // random phases
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4: win = WINDOW_W'($urandom_range(1, 16));
            5, 6, 7:       win = WINDOW_W'($urandom_range(17, 120));
            8:             win = WINDOW_W'($urandom_range(121, 1500));
            default:       win = WINDOW_W'($urandom_range(1));
         endcase
         case ($urandom_range(3))
            0:       fac = '0;
            1:       fac = FACTOR_MAX;
            2:       fac = FACTOR_RESET;
            default: fac = FACTOR_W'($urandom_range(FACTOR_MAX));
         endcase
         case ($urandom_range(5))
            0:       low_pct = 0;
            1:       low_pct = 100;
            2:       low_pct = 3;
            3:       low_pct = 97;
            4:       low_pct = 50;
            default: low_pct = $urandom_range(100);
         endcase
         count = $urandom_range(40, 160);
         set_regs(win, fac);
         start_stream(17, 17, 0);
         queue_random(count, low_pct);
         settle();
         random_items += count;
      end

      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
